[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file.
// Clock and reset names are those of the top level ports.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, muted while reset is held.
`define TCVD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds during reset.
`define TCVD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[hw/rtl/tcvd_pkg.sv]
// Shared types, constants and helpers of the trigger/CV command dispatcher.
// No dependencies.
`default_nettype none

package tcvd_pkg;

    // Sizes
    localparam int PORTS     = 8;
    localparam int FRAME_LEN = 32;
    localparam int MAX_OUT   = 8;
    localparam int NOUT      = (PORTS < MAX_OUT) ? PORTS : MAX_OUT;
    localparam int PORT_W    = $clog2(PORTS);
    localparam int OFS_W     = 5;
    localparam int LEN_W     = 29;
    localparam int STEP_W    = 31;
    localparam int TGT_W     = 18;
    localparam int CUR_W     = 34;
    localparam int DIFF_W    = 35;
    localparam int LIM_W     = 32;
    localparam int DEN_W     = 29;
    localparam int DIV_W     = 36;
    localparam int DIVC_W    = 6;
    localparam int MS_W      = 32;
    localparam int MSC_W     = 22;
    localparam int SPM_W     = 7;
    localparam int CFG_W     = 16;
    localparam int CFGI_W    = 1;

    localparam logic [LEN_W-1:0]  FRAME_LEN_L = LEN_W'(FRAME_LEN);
    localparam logic [DEN_W-1:0]  FRAME_LEN_D = DEN_W'(FRAME_LEN);
    localparam logic [STEP_W-1:0] FULL_STEP   = STEP_W'(64'd1 << 30);
    localparam logic [DIV_W-1:0]  DIVIDEND    = DIV_W'(64'(FRAME_LEN) << 30);
    localparam logic signed [MS_W-1:0] MAX_TIME_MS = 32'sd3600000;
    localparam logic [DIVC_W-1:0] DIV_LAST    = DIVC_W'(DIV_W - 1);
    localparam logic [SPM_W-1:0]  SPM_RESET   = 7'd48;

    // Configuration register indexes
    localparam logic [CFGI_W-1:0] CFG_SPM      = 1'b0;
    localparam logic [CFGI_W-1:0] CFG_DEF_SLEW = 1'b1;

    // Bus commands
    localparam logic [7:0] CMD_TR_SET     = 8'h00;
    localparam logic [7:0] CMD_TR_TOG     = 8'h01;
    localparam logic [7:0] CMD_PLEN_MS    = 8'h02;
    localparam logic [7:0] CMD_PLEN_S     = 8'h03;
    localparam logic [7:0] CMD_PLEN_MIN   = 8'h04;
    localparam logic [7:0] CMD_TR_PULSE   = 8'h05;
    localparam logic [7:0] CMD_TR_POL     = 8'h06;
    localparam logic [7:0] CMD_CV_SET     = 8'h10;
    localparam logic [7:0] CMD_CV_JUMP    = 8'h11;
    localparam logic [7:0] CMD_SLEW_MS    = 8'h12;
    localparam logic [7:0] CMD_SLEW_S     = 8'h13;
    localparam logic [7:0] CMD_SLEW_MIN   = 8'h14;
    localparam logic [7:0] CMD_CV_OFFSET  = 8'h15;

    typedef enum logic [1:0] {
        FN_MSG  = 2'd0,
        FN_TICK = 2'd1,
        FN_SOFT = 2'd2,
        FN_HARD = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        K_SIMPLE,
        K_PULSE_LEN,
        K_SLEW
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_PULSE0,
        S_APPLY,
        S_MUL_MS,
        S_MUL_SPM,
        S_DIV_INIT,
        S_DIV_STEP,
        S_WR_TIME,
        S_EMIT,
        S_UPD_A,
        S_UPD_B
    } t_state;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_CAPTURE,
        OP_SOFT,
        OP_LOAD_DEF,
        OP_PULSE0,
        OP_APPLY,
        OP_MUL_MS,
        OP_MUL_SPM,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_WR_PULSE,
        OP_WR_SLEW,
        OP_HARD,
        OP_EMIT,
        OP_UPD_A,
        OP_UPD_B
    } t_dp_op;

    // Controller to datapath
    typedef struct packed {
        t_dp_op            op;
        logic [PORT_W-1:0] port;
        logic              last;
    } t_dp_ctl;

    // Datapath to controller
    typedef struct packed {
        t_func func;
        logic  empty;
        t_kind kind;
        logic  out_free;
    } t_dp_stat;

    // Saturate an 18-bit CV value into the 17-bit output range
    function automatic logic signed [16:0] sat17(input logic signed [17:0] v);
        logic signed [16:0] r;
        if (v > 18'sd65535) begin
            r = 17'sd65535;
        end else if (v < -18'sd65536) begin
            r = -17'sd65536;
        end else begin
            r = v[16:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/trigger_cv_command_dispatcher.sv]
// Trigger/CV command dispatcher. One request is worked at a time; the input
// is stalled until it is done. A pulse length command adds the time
// multiplies, and a slew time command also runs the 36-step restoring
// divider that forms the slew step; a hard reset runs the divider for the
// same reason, a soft reset does not. A frame tick loads the result register
// for each port, waiting while the output is stalled, then runs the trigger
// and CV slew update of that port. Results leave through a single output
// register.
// Depends on tcvd_pkg, tcvd_ctrl and tcvd_datapath.
`default_nettype none

module trigger_cv_command_dispatcher import tcvd_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [CFGI_W-1:0]   i_cfg_index,
    input  wire logic [CFG_W-1:0]    i_cfg_data,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [1:0]          i_func,
    input  wire logic [7:0]          i_msg_length,
    input  wire logic [7:0]          i_command,
    input  wire logic [7:0]          i_port_byte,
    input  wire logic signed [15:0]  i_value,
    input  wire logic signed [15:0]  i_delay_samples,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [2:0]               o_port_index,
    output logic                     o_level_before,
    output logic                     o_level_after,
    output logic [4:0]               o_tr_offset,
    output logic signed [16:0]       o_cv_now,
    output logic signed [16:0]       o_cv_goal,
    output logic [4:0]               o_cv_offset_at,
    output logic                     o_slew_on,
    output logic                     o_last
);

    t_dp_ctl  ctl;
    t_dp_stat stat;

    tcvd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_ctl      (ctl)
    );

    tcvd_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .o_stat          (stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_func          (i_func),
        .i_msg_length    (i_msg_length),
        .i_command       (i_command),
        .i_port_byte     (i_port_byte),
        .i_value         (i_value),
        .i_delay_samples (i_delay_samples),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_port_index    (o_port_index),
        .o_level_before  (o_level_before),
        .o_level_after   (o_level_after),
        .o_tr_offset     (o_tr_offset),
        .o_cv_now        (o_cv_now),
        .o_cv_goal       (o_cv_goal),
        .o_cv_offset_at  (o_cv_offset_at),
        .o_slew_on       (o_slew_on),
        .o_last          (o_last)
    );

endmodule

`default_nettype wire

[hw/rtl/tcvd_ctrl.sv]
// Sequencer of the dispatcher: walks message, reset and frame tick requests.
// Depends on tcvd_pkg.
`default_nettype none

module tcvd_ctrl import tcvd_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_dp_stat i_stat,
    output t_dp_ctl       o_ctl
);

    t_state              r_state, n_state;
    logic [PORT_W-1:0]   r_port, n_port;
    logic                r_hard, n_hard;
    logic [DIVC_W-1:0]   r_div_cnt, n_div_cnt;
    logic                emit_port;

    assign emit_port = ({1'b0, r_port} < (PORT_W+1)'(NOUT));

    // State and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_port    <= '0;
            r_hard    <= 1'b0;
            r_div_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_port    <= n_port;
            r_hard    <= n_hard;
            r_div_cnt <= n_div_cnt;
        end
    end

    // Next state
    always_comb begin
        n_state   = r_state;
        n_port    = r_port;
        n_hard    = r_hard;
        n_div_cnt = r_div_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                unique case (i_stat.func)
                    FN_SOFT: n_state = S_IDLE;
                    FN_HARD: begin
                        n_hard  = 1'b1;
                        n_state = S_MUL_SPM;
                    end
                    FN_TICK: begin
                        n_port  = '0;
                        n_state = S_EMIT;
                    end
                    default: begin
                        n_hard  = 1'b0;
                        n_state = i_stat.empty ? S_IDLE : S_PULSE0;
                    end
                endcase
            end
            S_PULSE0: n_state = (i_stat.kind == K_SIMPLE) ? S_APPLY : S_MUL_MS;
            S_APPLY:  n_state = S_IDLE;
            S_MUL_MS: n_state = S_MUL_SPM;
            S_MUL_SPM: begin
                n_state = (!r_hard && i_stat.kind == K_PULSE_LEN) ? S_WR_TIME : S_DIV_INIT;
            end
            S_DIV_INIT: begin
                n_div_cnt = '0;
                n_state   = S_DIV_STEP;
            end
            S_DIV_STEP: begin
                n_div_cnt = r_div_cnt + 1'b1;
                if (r_div_cnt == DIV_LAST) n_state = S_WR_TIME;
            end
            S_WR_TIME: n_state = S_IDLE;
            S_EMIT: begin
                if (!emit_port || i_stat.out_free) n_state = S_UPD_A;
            end
            S_UPD_A: n_state = S_UPD_B;
            S_UPD_B: begin
                if (r_port == PORT_W'(PORTS - 1)) begin
                    n_port  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_port  = r_port + 1'b1;
                    n_state = S_EMIT;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_ctl.op   = OP_NOP;
        o_ctl.port = r_port;
        o_ctl.last = (r_port == PORT_W'(NOUT - 1));
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) o_ctl.op = OP_CAPTURE;
            end
            S_DISPATCH: begin
                unique case (i_stat.func)
                    FN_SOFT: o_ctl.op = OP_SOFT;
                    FN_HARD: o_ctl.op = OP_LOAD_DEF;
                    default: o_ctl.op = OP_NOP;
                endcase
            end
            S_PULSE0:   o_ctl.op = OP_PULSE0;
            S_APPLY:    o_ctl.op = OP_APPLY;
            S_MUL_MS:   o_ctl.op = OP_MUL_MS;
            S_MUL_SPM:  o_ctl.op = OP_MUL_SPM;
            S_DIV_INIT: o_ctl.op = OP_DIV_INIT;
            S_DIV_STEP: o_ctl.op = OP_DIV_STEP;
            S_WR_TIME: begin
                if (r_hard) begin
                    o_ctl.op = OP_HARD;
                end else if (i_stat.kind == K_PULSE_LEN) begin
                    o_ctl.op = OP_WR_PULSE;
                end else begin
                    o_ctl.op = OP_WR_SLEW;
                end
            end
            S_EMIT: begin
                if (emit_port && i_stat.out_free) o_ctl.op = OP_EMIT;
            end
            S_UPD_A: o_ctl.op = OP_UPD_A;
            S_UPD_B: o_ctl.op = OP_UPD_B;
            default: o_ctl.op = OP_NOP;
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/tcvd_datapath.sv]
// Datapath of the dispatcher: per-port state, time multipliers, slew divider,
// frame update arithmetic and the result register. Depends on tcvd_pkg.
`default_nettype none

module tcvd_datapath import tcvd_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_dp_ctl                  i_ctl,
    output t_dp_stat                      o_stat,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFGI_W-1:0]        i_cfg_index,
    input  wire logic [CFG_W-1:0]         i_cfg_data,
    input  wire logic [1:0]               i_func,
    input  wire logic [7:0]               i_msg_length,
    input  wire logic [7:0]               i_command,
    input  wire logic [7:0]               i_port_byte,
    input  wire logic signed [15:0]       i_value,
    input  wire logic signed [15:0]       i_delay_samples,
    input  wire logic                     i_out_stall,
    output logic                          o_out_valid,
    output logic [2:0]                    o_port_index,
    output logic                          o_level_before,
    output logic                          o_level_after,
    output logic [4:0]                    o_tr_offset,
    output logic signed [16:0]            o_cv_now,
    output logic signed [16:0]            o_cv_goal,
    output logic [4:0]                    o_cv_offset_at,
    output logic                          o_slew_on,
    output logic                          o_last
);

    localparam logic signed [15:0] DL_MAX = 16'(FRAME_LEN - 1);

    // Configuration
    logic [SPM_W-1:0]        r_spm;
    logic signed [15:0]      r_def_slew;

    // Captured request
    logic [1:0]              r_func;
    logic [7:0]              r_len;
    logic [7:0]              r_cmd;
    logic [7:0]              r_pb;
    logic signed [15:0]      r_val;
    logic signed [15:0]      r_dl;

    // Per-port state
    logic                    r_prev   [PORTS];
    logic                    r_next   [PORTS];
    logic [OFS_W-1:0]        r_switch [PORTS];
    logic                    r_busy   [PORTS];
    logic [LEN_W-1:0]        r_left   [PORTS];
    logic [LEN_W-1:0]        r_plen   [PORTS];
    logic                    r_pol    [PORTS];
    logic signed [15:0]      r_off    [PORTS];
    logic signed [TGT_W-1:0] r_tgt    [PORTS];
    logic signed [CUR_W-1:0] r_cur    [PORTS];
    logic [OFS_W-1:0]        r_jump   [PORTS];
    logic [STEP_W-1:0]       r_step   [PORTS];
    logic                    r_flag   [PORTS];

    // Arithmetic registers
    logic signed [MS_W-1:0]   r_ms;
    logic [DEN_W-1:0]         r_den;
    logic [DIV_W-1:0]         r_quo;
    logic [DEN_W-1:0]         r_rem;
    logic [LIM_W-1:0]         r_lim;
    logic signed [DIFF_W-1:0] r_diff;

    logic                     r_out_valid;

    // Decoded request fields
    logic signed [15:0]      val_eff;
    logic [OFS_W-1:0]        d;
    logic [8:0]              psum;
    logic [PORT_W-1:0]       mp;
    logic [PORT_W-1:0]       ap;
    logic                    val_nz;
    t_kind                   kind;
    logic [15:0]             mult_k;

    assign val_eff = (r_len > 8'd3) ? r_val : 16'sd0;
    assign val_nz  = (val_eff != 16'sd0);
    assign psum    = {1'b0, r_pb} + 9'd1;

    always_comb begin
        if (r_dl < 16'sd0) begin
            d = '0;
        end else if (r_dl > DL_MAX) begin
            d = OFS_W'(FRAME_LEN - 1);
        end else begin
            d = r_dl[OFS_W-1:0];
        end
        if (r_len > 8'd1) begin
            mp = (psum > 9'(PORTS - 1)) ? PORT_W'(PORTS - 1) : psum[PORT_W-1:0];
        end else begin
            mp = '0;
        end
    end

    // Tick ops address the controller's port, message ops the decoded one
    assign ap = (i_ctl.op == OP_EMIT || i_ctl.op == OP_UPD_A || i_ctl.op == OP_UPD_B)
                ? i_ctl.port : mp;

    // Command class and time unit
    always_comb begin
        unique case (r_cmd) inside
            CMD_PLEN_MS, CMD_PLEN_S, CMD_PLEN_MIN: kind = K_PULSE_LEN;
            CMD_SLEW_MS, CMD_SLEW_S, CMD_SLEW_MIN: kind = K_SLEW;
            default:                               kind = K_SIMPLE;
        endcase
        unique case (r_cmd) inside
            CMD_PLEN_S, CMD_SLEW_S:     mult_k = 16'd1000;
            CMD_PLEN_MIN, CMD_SLEW_MIN: mult_k = 16'd60000;
            default:                    mult_k = 16'd1;
        endcase
    end

    assign o_stat.func     = t_func'(r_func);
    assign o_stat.empty    = (r_len == 8'd0);
    assign o_stat.kind     = kind;
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    // Message arithmetic
    logic signed [TGT_W-1:0] a_tgt_set;
    logic signed [TGT_W-1:0] a_tgt_ofs;
    logic [LEN_W-1:0]        a_pleft;
    logic [LEN_W-1:0]        p0_left;
    logic [MSC_W-1:0]        m_clamp;
    logic [DEN_W-1:0]        u_den;
    logic [LEN_W-1:0]        n_plen;
    logic [STEP_W-1:0]       n_step;
    logic                    n_flag;
    logic [DEN_W:0]          div_trial;
    logic                    div_bit;

    assign a_tgt_set = TGT_W'(val_eff) + TGT_W'(r_off[ap]);
    assign a_tgt_ofs = r_tgt[ap] - TGT_W'(r_off[ap]) + TGT_W'(val_eff);
    assign a_pleft   = r_plen[ap] - FRAME_LEN_L + LEN_W'(d);
    assign p0_left   = r_plen[0] - FRAME_LEN_L + LEN_W'(d);

    always_comb begin
        if (r_ms <= 32'sd0) begin
            m_clamp = '0;
        end else if (r_ms > MAX_TIME_MS) begin
            m_clamp = MAX_TIME_MS[MSC_W-1:0];
        end else begin
            m_clamp = r_ms[MSC_W-1:0];
        end
    end
    assign u_den  = m_clamp * r_spm;
    assign n_plen = (r_den < FRAME_LEN_D) ? FRAME_LEN_L : r_den;
    assign n_step = (r_den <= FRAME_LEN_D) ? FULL_STEP : r_quo[STEP_W-1:0];
    assign n_flag = (r_ms > 32'sd0);

    // One quotient bit per step
    assign div_trial = {r_rem, r_quo[DIV_W-1]};
    assign div_bit   = (div_trial >= {1'b0, r_den});

    // Frame update arithmetic
    logic [5:0]               jr;
    logic [36:0]              u_prod;
    logic signed [DIFF_W-1:0] u_diff;
    logic signed [DIFF_W-1:0] lim_s;
    logic signed [DIFF_W-1:0] clamp_d;

    assign jr     = 6'(FRAME_LEN) - {1'b0, r_jump[ap]};
    assign u_prod = r_step[ap] * jr;
    assign u_diff = DIFF_W'($signed({r_tgt[ap], 16'h0000})) - DIFF_W'(r_cur[ap]);
    assign lim_s  = $signed({3'b000, r_lim});

    always_comb begin
        if (r_diff > lim_s) begin
            clamp_d = lim_s;
        end else if (r_diff < -lim_s) begin
            clamp_d = -lim_s;
        end else begin
            clamp_d = r_diff;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spm      <= SPM_RESET;
            r_def_slew <= 16'sd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SPM:      r_spm      <= i_cfg_data[SPM_W-1:0];
                CFG_DEF_SLEW: r_def_slew <= i_cfg_data;
                default:      r_spm      <= r_spm;
            endcase
        end
    end

    // Request capture and arithmetic registers
    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            OP_CAPTURE: begin
                r_func <= i_func;
                r_len  <= i_msg_length;
                r_cmd  <= i_command;
                r_pb   <= i_port_byte;
                r_val  <= i_value;
                r_dl   <= i_delay_samples;
            end
            OP_LOAD_DEF: r_ms  <= MS_W'(r_def_slew);
            OP_MUL_MS:   r_ms  <= MS_W'(val_eff) * MS_W'($signed({1'b0, mult_k}));
            OP_MUL_SPM:  r_den <= u_den;
            OP_DIV_INIT: begin
                r_quo <= DIVIDEND;
                r_rem <= '0;
            end
            OP_DIV_STEP: begin
                r_rem <= div_bit ? DEN_W'(div_trial - {1'b0, r_den}) : div_trial[DEN_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], div_bit};
            end
            OP_UPD_A: begin
                r_lim  <= u_prod[36:5];
                r_diff <= u_diff;
            end
            default: r_lim <= r_lim;
        endcase
    end

    // Per-port state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PORTS; i++) begin
                r_prev[i]   <= 1'b0;
                r_next[i]   <= 1'b0;
                r_switch[i] <= '0;
                r_busy[i]   <= 1'b0;
                r_left[i]   <= '0;
                r_plen[i]   <= FRAME_LEN_L;
                r_pol[i]    <= 1'b1;
                r_off[i]    <= 16'sd0;
                r_tgt[i]    <= '0;
                r_cur[i]    <= '0;
                r_jump[i]   <= '0;
                r_step[i]   <= FULL_STEP;
                r_flag[i]   <= 1'b0;
            end
        end else begin
            case (i_ctl.op)
                OP_SOFT: begin
                    for (int i = 0; i < PORTS; i++) begin
                        r_prev[i]   <= ~r_pol[i];
                        r_next[i]   <= ~r_pol[i];
                        r_switch[i] <= '0;
                        r_busy[i]   <= 1'b0;
                        r_left[i]   <= '0;
                        r_tgt[i]    <= '0;
                        r_cur[i]    <= '0;
                        r_jump[i]   <= '0;
                    end
                end
                OP_HARD: begin
                    for (int i = 0; i < PORTS; i++) begin
                        r_prev[i]   <= 1'b0;
                        r_next[i]   <= 1'b0;
                        r_switch[i] <= '0;
                        r_busy[i]   <= 1'b0;
                        r_left[i]   <= '0;
                        r_plen[i]   <= FRAME_LEN_L;
                        r_pol[i]    <= 1'b1;
                        r_off[i]    <= 16'sd0;
                        r_tgt[i]    <= '0;
                        r_cur[i]    <= '0;
                        r_jump[i]   <= '0;
                        r_step[i]   <= n_step;
                        r_flag[i]   <= n_flag;
                    end
                end
                // Diagnostic pulse on port 0
                OP_PULSE0: begin
                    r_busy[0]   <= 1'b1;
                    r_left[0]   <= p0_left;
                    r_prev[0]   <= r_next[0];
                    r_next[0]   <= r_pol[0];
                    r_switch[0] <= d;
                end
                OP_APPLY: begin
                    case (r_cmd)
                        CMD_TR_SET: begin
                            r_prev[ap]   <= r_next[ap];
                            r_next[ap]   <= val_nz ? r_pol[ap] : ~r_pol[ap];
                            r_switch[ap] <= d;
                            r_busy[ap]   <= 1'b0;
                            r_left[ap]   <= '0;
                        end
                        CMD_TR_TOG: begin
                            r_prev[ap]   <= r_next[ap];
                            r_next[ap]   <= ~r_next[ap];
                            r_switch[ap] <= d;
                            r_busy[ap]   <= 1'b0;
                            r_left[ap]   <= '0;
                        end
                        CMD_TR_PULSE: begin
                            r_busy[ap]   <= 1'b1;
                            r_left[ap]   <= a_pleft;
                            r_prev[ap]   <= r_next[ap];
                            r_next[ap]   <= r_pol[ap];
                            r_switch[ap] <= d;
                        end
                        // A polarity change inverts the present level
                        CMD_TR_POL: begin
                            if (val_nz != r_pol[ap]) begin
                                r_pol[ap]    <= val_nz;
                                r_prev[ap]   <= r_next[ap];
                                r_next[ap]   <= ~r_next[ap];
                                r_switch[ap] <= d;
                                r_busy[ap]   <= 1'b0;
                                r_left[ap]   <= '0;
                            end
                        end
                        CMD_CV_SET: begin
                            r_tgt[ap]  <= a_tgt_set;
                            r_jump[ap] <= d;
                        end
                        CMD_CV_JUMP: begin
                            r_tgt[ap]  <= a_tgt_set;
                            r_jump[ap] <= d;
                            r_cur[ap]  <= $signed({a_tgt_set, 16'h0000});
                        end
                        CMD_CV_OFFSET: begin
                            r_tgt[ap]  <= a_tgt_ofs;
                            r_off[ap]  <= val_eff;
                            r_jump[ap] <= d;
                        end
                        default: r_jump[ap] <= r_jump[ap];
                    endcase
                end
                OP_WR_PULSE: begin
                    r_plen[ap] <= n_plen;
                    if (r_left[ap] > n_plen) r_left[ap] <= n_plen;
                end
                OP_WR_SLEW: begin
                    r_step[ap] <= n_step;
                    r_flag[ap] <= n_flag;
                end
                // Trigger side of the frame update
                OP_UPD_A: begin
                    r_prev[ap] <= r_next[ap];
                    if (r_busy[ap] && r_left[ap] < FRAME_LEN_L) begin
                        r_next[ap]   <= ~r_pol[ap];
                        r_switch[ap] <= r_left[ap][OFS_W-1:0];
                        r_busy[ap]   <= 1'b0;
                        r_left[ap]   <= '0;
                    end else begin
                        if (r_busy[ap]) r_left[ap] <= r_left[ap] - FRAME_LEN_L;
                        r_switch[ap] <= '0;
                    end
                end
                // CV slew by at most the limit
                OP_UPD_B: begin
                    r_cur[ap]  <= r_cur[ap] + CUR_W'(clamp_d);
                    r_jump[ap] <= '0;
                end
                default: r_busy[0] <= r_busy[0];
            endcase
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.op == OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.op == OP_EMIT) begin
            o_port_index   <= 3'(ap);
            o_level_before <= r_prev[ap];
            o_level_after  <= r_next[ap];
            o_tr_offset    <= r_switch[ap];
            o_cv_now       <= sat17($signed(r_cur[ap][CUR_W-1:16]));
            o_cv_goal      <= sat17(r_tgt[ap]);
            o_cv_offset_at <= r_jump[ap];
            o_slew_on      <= r_flag[ap];
            o_last         <= i_ctl.last;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

[hw/rtl/tcvd_checker.sv]
// Port-level checks of the dispatcher, bound to the top level.
// Depends on tcvd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tcvd_checker import tcvd_pkg::*; (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_stall,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [2:0] o_port_index,
    input wire logic       o_last
);

    // A pending result holds while stalled
    `TCVD_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid, "result dropped")

    // One request at a time
    `TCVD_ASSERT(a_one_req, i_in_valid && !o_in_stall |=> o_in_stall, "request overlap")

    // No request taken in the middle of a frame tick
    `TCVD_ASSERT(a_tick_busy, o_out_valid && !o_last |-> o_in_stall, "request during tick")

    // The final result of a tick is the last reported port
    `TCVD_ASSERT(a_last_port, o_out_valid && o_last |-> o_port_index == 3'(NOUT - 1),
        "last flag on wrong port")

endmodule

bind trigger_cv_command_dispatcher tcvd_checker u_tcvd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_port_index (o_port_index),
    .o_last       (o_last)
);

`default_nettype wire

[test/tb.sv]
// Self-checking bench for trigger_cv_command_dispatcher: directed table, then random
// requests, with a built-in port/trigger/CV predictor. Depends on tcvd_pkg and the RTL.
`default_nettype none

module tb;
    import tcvd_pkg::*;

    localparam int DIR_ROWS = 26;
    localparam int WD_LIMIT = 3000;
    localparam int SETTLE   = 60;

    typedef struct {
        t_func                fn;
        bit [7:0]             len;
        bit [7:0]             cmd;
        bit [7:0]             pb;
        bit signed [15:0]     val;
        bit signed [15:0]     dl;
        bit                   idle_tick;
    } req_t;

    typedef struct {
        bit [2:0]         port;
        bit               lvl_b;
        bit               lvl_a;
        bit [4:0]         ofs;
        bit signed [16:0] now;
        bit signed [16:0] goal;
        bit [4:0]         jat;
        bit               slew;
        bit               last;
    } port_rpt_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CFGI_W-1:0]   i_cfg_index;
    logic [CFG_W-1:0]    i_cfg_data;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [1:0]          i_func;
    logic [7:0]          i_msg_length;
    logic [7:0]          i_command;
    logic [7:0]          i_port_byte;
    logic signed [15:0]  i_value;
    logic signed [15:0]  i_delay_samples;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [2:0]          o_port_index;
    logic                o_level_before;
    logic                o_level_after;
    logic [4:0]          o_tr_offset;
    logic signed [16:0]  o_cv_now;
    logic signed [16:0]  o_cv_goal;
    logic [4:0]          o_cv_offset_at;
    logic                o_slew_on;
    logic                o_last;

    trigger_cv_command_dispatcher u_top (.*);

    always #4 i_clk = ~i_clk;

    // Predictor state
    bit [6:0]         spm;
    bit signed [15:0] def_slew;
    bit               tr_prev  [PORTS];
    bit               tr_next  [PORTS];
    bit [4:0]         tr_sw    [PORTS];
    bit               pls_busy [PORTS];
    int unsigned      pls_left [PORTS];
    int unsigned      pls_len  [PORTS];
    bit               pol_high [PORTS];
    int               cv_ofs   [PORTS];
    int               cv_tgt   [PORTS];
    longint           cv_cur   [PORTS];
    bit [4:0]         cv_jat   [PORTS];
    bit [30:0]        slew_stp [PORTS];
    bit               slew_en  [PORTS];

    port_rpt_t pending_reports[$];
    int        n_errors;
    int        n_reqs;
    int        n_reports;
    int        gap_burst;
    int        stall_burst;
    bit        long_hold_req;
    bit        stim_done;

    function automatic bit idle_level(int p);
        return pol_high[p] ? 1'b0 : 1'b1;
    endfunction

    function automatic void load_slew(int p, longint ms);
        longint m, den;
        m   = (ms < 3600000) ? ms : 3600000;
        den = m * longint'(spm);
        if (den <= FRAME_LEN) slew_stp[p] = FULL_STEP;
        else slew_stp[p] = 31'((longint'(FRAME_LEN) << 30) / den);
        slew_en[p] = ms > 0;
    endfunction

    function automatic void load_pulse_len(int p, longint ms);
        longint m, n;
        m = (ms < 3600000) ? ms : 3600000;
        n = m * longint'(spm);
        if (n < FRAME_LEN) n = FRAME_LEN;
        pls_len[p] = int'(n);
        if (longint'(pls_left[p]) > n) pls_left[p] = int'(n);
    endfunction

    function automatic void trig_set(bit [4:0] d, int p, bit on);
        tr_prev[p]  = tr_next[p];
        tr_next[p]  = on ? ~idle_level(p) : idle_level(p);
        tr_sw[p]    = d;
        pls_busy[p] = 0;
        pls_left[p] = 0;
    endfunction

    function automatic void trig_toggle(bit [4:0] d, int p);
        tr_prev[p]  = tr_next[p];
        tr_next[p]  = ~tr_next[p];
        tr_sw[p]    = d;
        pls_busy[p] = 0;
        pls_left[p] = 0;
    endfunction

    function automatic void trig_pulse(bit [4:0] d, int p);
        pls_busy[p] = 1;
        pls_left[p] = pls_len[p] - FRAME_LEN + d;
        tr_prev[p]  = tr_next[p];
        tr_next[p]  = ~idle_level(p);
        tr_sw[p]    = d;
    endfunction

    function automatic void clear_ports();
        for (int p = 0; p < PORTS; p++) begin
            tr_prev[p]  = idle_level(p);
            tr_next[p]  = idle_level(p);
            tr_sw[p]    = 0;
            pls_busy[p] = 0;
            pls_left[p] = 0;
            cv_tgt[p]   = 0;
            cv_cur[p]   = 0;
            cv_jat[p]   = 0;
        end
    endfunction

    function automatic void restore_ports();
        for (int p = 0; p < PORTS; p++) begin
            pol_high[p] = 1;
            pls_len[p]  = FRAME_LEN;
            cv_ofs[p]   = 0;
            load_slew(p, def_slew);
        end
        clear_ports();
    endfunction

    function automatic bit signed [16:0] clamp17(longint v);
        if (v > 65535) v = 65535;
        if (v < -65536) v = -65536;
        return 17'(v);
    endfunction

    // End or continue pulses, then slew each CV by the frame's share of its step
    function automatic void advance_frame();
        longint lim, diff;
        for (int p = 0; p < PORTS; p++) begin
            if (pls_busy[p] && pls_left[p] < FRAME_LEN) begin
                trig_set(5'(pls_left[p]), p, 1'b0);
            end else begin
                if (pls_busy[p]) pls_left[p] -= FRAME_LEN;
                tr_prev[p] = tr_next[p];
                tr_sw[p]   = 0;
            end
            lim  = (longint'(slew_stp[p]) * (FRAME_LEN - longint'(cv_jat[p]))) / FRAME_LEN;
            diff = longint'(cv_tgt[p]) * 65536 - cv_cur[p];
            if (diff > lim) diff = lim;
            if (diff < -lim) diff = -lim;
            cv_cur[p] += diff;
            cv_jat[p] = 0;
        end
    endfunction

    // Apply one accepted request and queue the port reports it produces
    function automatic void predict_request(req_t r);
        port_rpt_t rp;
        int        p, dl, val;
        bit [4:0]  d;
        case (r.fn)
            FN_SOFT: clear_ports();
            FN_HARD: restore_ports();
            FN_TICK: begin
                for (p = 0; p < NOUT; p++) begin
                    rp.port  = 3'(p);
                    rp.lvl_b = tr_prev[p];
                    rp.lvl_a = tr_next[p];
                    rp.ofs   = tr_sw[p];
                    rp.now   = clamp17(cv_cur[p] >>> 16);
                    rp.goal  = clamp17(cv_tgt[p]);
                    rp.jat   = cv_jat[p];
                    rp.slew  = slew_en[p];
                    rp.last  = (p == NOUT - 1);
                    if (r.idle_tick) begin
                        // after power-up or hard reset: inactive triggers, zero CV, no slew
                        rp = '{3'(p), 0, 0, 0, 0, 0, 0, 0, p == NOUT - 1};
                    end
                    pending_reports.push_back(rp);
                end
                advance_frame();
            end
            default: begin
                if (r.len != 0) begin
                    val = (r.len > 3) ? int'(r.val) : 0;
                    dl  = int'(r.dl);
                    if (dl < 0) dl = 0;
                    if (dl > FRAME_LEN - 1) dl = FRAME_LEN - 1;
                    d = 5'(dl);
                    p = 0;
                    if (r.len > 1) begin
                        p = int'(r.pb) + 1;
                        if (p > PORTS - 1) p = PORTS - 1;
                    end
                    // diagnostic port 0 pulses on every non-empty message
                    trig_pulse(d, 0);
                    case (r.cmd)
                        CMD_TR_SET:   trig_set(d, p, val != 0);
                        CMD_TR_TOG:   trig_toggle(d, p);
                        CMD_PLEN_MS:  load_pulse_len(p, val);
                        CMD_PLEN_S:   load_pulse_len(p, longint'(val) * 1000);
                        CMD_PLEN_MIN: load_pulse_len(p, longint'(val) * 60000);
                        CMD_TR_PULSE: trig_pulse(d, p);
                        CMD_TR_POL: begin
                            if ((val != 0) != pol_high[p]) begin
                                pol_high[p] = val != 0;
                                trig_toggle(d, p);
                            end
                        end
                        CMD_CV_SET: begin
                            cv_tgt[p] = val + cv_ofs[p];
                            cv_jat[p] = d;
                        end
                        CMD_CV_JUMP: begin
                            cv_tgt[p] = val + cv_ofs[p];
                            cv_jat[p] = d;
                            cv_cur[p] = longint'(cv_tgt[p]) * 65536;
                        end
                        CMD_SLEW_MS:  load_slew(p, val);
                        CMD_SLEW_S:   load_slew(p, longint'(val) * 1000);
                        CMD_SLEW_MIN: load_slew(p, longint'(val) * 60000);
                        CMD_CV_OFFSET: begin
                            cv_tgt[p] = cv_tgt[p] - cv_ofs[p] + val;
                            cv_ofs[p] = val;
                            cv_jat[p] = d;
                        end
                        default: ;
                    endcase
                end
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("tb: mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    // Directed table; idle_tick rows carry the typed after-reset result
    req_t dir_rows[DIR_ROWS] = '{
        '{FN_TICK, 8'd4,   CMD_TR_SET,    8'd0,   16'sd0,      16'sd0,      1'b1},
        '{FN_MSG,  8'd0,   CMD_TR_SET,    8'd0,   16'sd1,      16'sd3,      1'b0},
        '{FN_MSG,  8'd1,   CMD_TR_SET,    8'd9,   16'sd5,      -16'sd32768, 1'b0},
        '{FN_MSG,  8'd4,   CMD_TR_SET,    8'd0,   16'sd1,      16'sd3,      1'b0},
        '{FN_MSG,  8'd4,   CMD_TR_TOG,    8'd255, 16'sd0,      16'sd32767,  1'b0},
        '{FN_TICK, 8'd0,   8'd0,          8'd0,   16'sd0,      16'sd0,      1'b0},
        '{FN_MSG,  8'd4,   CMD_PLEN_MS,   8'd1,   16'sd1,      16'sd0,      1'b0},
        '{FN_MSG,  8'd4,   CMD_TR_PULSE,  8'd1,   16'sd0,      16'sd20,     1'b0},
        '{FN_TICK, 8'd0,   8'd0,          8'd0,   16'sd0,      16'sd0,      1'b0},
        '{FN_TICK, 8'd0,   8'd0,          8'd0,   16'sd0,      16'sd0,      1'b0},
        '{FN_MSG,  8'd4,   CMD_PLEN_S,    8'd2,   16'sd32767,  16'sd5,      1'b0},
        '{FN_MSG,  8'd4,   CMD_PLEN_MIN,  8'd3,   -16'sd32768, 16'sd6,      1'b0},
        '{FN_MSG,  8'd4,   CMD_TR_POL,    8'd4,   16'sd0,      16'sd7,      1'b0},
        '{FN_MSG,  8'd4,   CMD_CV_SET,    8'd5,   16'sd32767,  16'sd16,     1'b0},
        '{FN_MSG,  8'd4,   CMD_CV_JUMP,   8'd6,   -16'sd32768, 16'sd31,     1'b0},
        '{FN_MSG,  8'd4,   CMD_SLEW_MS,   8'd5,   16'sd100,    16'sd2,      1'b0},
        '{FN_MSG,  8'd4,   CMD_SLEW_S,    8'd6,   16'sd1,      16'sd9,      1'b0},
        '{FN_MSG,  8'd4,   CMD_SLEW_MIN,  8'd0,   -16'sd1,     16'sd4,      1'b0},
        '{FN_MSG,  8'd255, CMD_CV_OFFSET, 8'd5,   16'sd32767,  16'sd1,      1'b0},
        '{FN_MSG,  8'd3,   8'hFF,         8'd254, 16'sd77,     16'sd12,     1'b0},
        '{FN_TICK, 8'd0,   8'd0,          8'd0,   16'sd0,      16'sd0,      1'b0},
        '{FN_TICK, 8'd0,   8'd0,          8'd0,   16'sd0,      16'sd0,      1'b0},
        '{FN_SOFT, 8'd0,   8'd0,          8'd0,   16'sd0,      16'sd0,      1'b0},
        '{FN_TICK, 8'd0,   8'd0,          8'd0,   16'sd0,      16'sd0,      1'b0},
        '{FN_HARD, 8'd0,   8'd0,          8'd0,   16'sd0,      16'sd0,      1'b0},
        '{FN_TICK, 8'd0,   8'd0,          8'd0,   16'sd0,      16'sd0,      1'b1}
    };

    bit [7:0] known_cmds[13] = '{CMD_TR_SET, CMD_TR_TOG, CMD_PLEN_MS, CMD_PLEN_S,
        CMD_PLEN_MIN, CMD_TR_PULSE, CMD_TR_POL, CMD_CV_SET, CMD_CV_JUMP,
        CMD_SLEW_MS, CMD_SLEW_S, CMD_SLEW_MIN, CMD_CV_OFFSET};

    function automatic req_t random_request();
        req_t r;
        int   k;
        k = $urandom_range(0, 99);
        r.fn = (k < 60) ? FN_MSG : (k < 92) ? FN_TICK : (k < 96) ? FN_SOFT : FN_HARD;
        r.len = ($urandom_range(0, 9) < 8) ? 8'd4 : 8'($urandom);
        r.cmd = ($urandom_range(0, 9) < 9) ? known_cmds[$urandom_range(0, 12)]
                                            : 8'($urandom);
        r.pb  = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 7)) : 8'($urandom);
        if (r.cmd inside {[CMD_PLEN_MS:CMD_PLEN_MIN], [CMD_SLEW_MS:CMD_SLEW_MIN]} &&
            $urandom_range(0, 9) < 7) begin
            r.val = 16'($urandom_range(0, 24)) - 16'sd2;
        end else begin
            r.val = 16'($urandom);
        end
        r.dl = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 31)) : 16'($urandom);
        r.idle_tick = 0;
        return r;
    endfunction

    // Offer one request and wait until it is taken
    task automatic send_request(req_t r);
        int gap;
        if (gap_burst > 0) begin
            gap_burst--;
            gap = 0;
        end else begin
            gap = $urandom_range(0, 10);
            if ($urandom_range(0, 15) == 0) gap_burst = $urandom_range(5, 20);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_func          <= r.fn;
        i_msg_length    <= r.len;
        i_command       <= r.cmd;
        i_port_byte     <= r.pb;
        i_value         <= r.val;
        i_delay_samples <= r.dl;
        do @(posedge i_clk); while (o_in_stall);
        predict_request(r);
        n_reqs++;
    endtask

    // Let the block drain so config registers can be written safely
    task automatic wait_idle();
        @(posedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_cfg(bit [CFGI_W-1:0] idx, bit [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_SPM) spm = 7'(data);
        else def_slew = data;
    endtask

    // Result side: random stall per report, one long hold on request
    initial begin
        int        w;
        port_rpt_t want;
        i_out_stall <= 1'b0;
        forever begin
            if (long_hold_req) begin
                long_hold_req = 0;
                w = 300;
            end else if (stall_burst > 0) begin
                stall_burst--;
                w = 0;
            end else begin
                w = $urandom_range(0, 10);
                if ($urandom_range(0, 15) == 0) stall_burst = $urandom_range(5, 25);
            end
            if (w > 0) begin
                i_out_stall <= 1'b1;
                repeat (w) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_out_valid);
            n_reports++;
            if (pending_reports.size() == 0) begin
                report_mismatch("unexpected report, port", o_port_index, -1);
            end else begin
                want = pending_reports.pop_front();
                if (o_port_index != want.port)
                    report_mismatch("port_index", o_port_index, want.port);
                if (o_level_before != want.lvl_b)
                    report_mismatch("level_before", o_level_before, want.lvl_b);
                if (o_level_after != want.lvl_a)
                    report_mismatch("level_after", o_level_after, want.lvl_a);
                if (o_tr_offset != want.ofs)
                    report_mismatch("tr_offset", o_tr_offset, want.ofs);
                if (o_cv_now != want.now)
                    report_mismatch("cv_now", longint'(o_cv_now), longint'(want.now));
                if (o_cv_goal != want.goal)
                    report_mismatch("cv_goal", longint'(o_cv_goal), longint'(want.goal));
                if (o_cv_offset_at != want.jat)
                    report_mismatch("cv_offset_at", o_cv_offset_at, want.jat);
                if (o_slew_on != want.slew)
                    report_mismatch("slew_on", o_slew_on, want.slew);
                if (o_last != want.last)
                    report_mismatch("last", o_last, want.last);
            end
        end
    end

    // Watchdog on cycles with no handshake on either side
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet = 0;
            else quiet++;
            if (quiet >= WD_LIMIT) begin
                $display("tb: watchdog expired with %0d reports pending",
                         pending_reports.size());
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Settings walked after the directed part: {samples_per_ms, default_slew_ms}
    int phase_spm[6]  = '{1, 96, 48, 7, 96, 1};
    int phase_slew[6] = '{-32768, 32767, 0, 300, 1, 32767};

    initial begin
        req_t r;
        n_errors = 0; n_reqs = 0; n_reports = 0;
        gap_burst = 0; stall_burst = 0; long_hold_req = 0; stim_done = 0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0; i_cfg_index <= '0; i_cfg_data <= '0;
        i_in_valid <= 1'b0; i_func <= '0; i_msg_length <= '0; i_command <= '0;
        i_port_byte <= '0; i_value <= '0; i_delay_samples <= '0;
        spm = SPM_RESET;
        def_slew = 0;
        restore_ports();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) send_request(dir_rows[i]);

        for (int ph = 0; ph < 6; ph++) begin
            wait_idle();
            write_cfg(CFG_SPM, CFG_W'(phase_spm[ph]));
            write_cfg(CFG_DEF_SLEW, CFG_W'(phase_slew[ph]));
            // hard reset picks up the new default slew
            r = dir_rows[DIR_ROWS - 2];
            send_request(r);
            for (int k = 0; k < 45; k++) begin
                if (ph == 1 && k == 10) begin
                    // hold results off while ticks keep coming
                    long_hold_req = 1;
                    r = dir_rows[5];
                    for (int t = 0; t < 4; t++) begin
                        gap_burst = 1;
                        send_request(r);
                    end
                end
                if (ph == 3 && k == 20) begin
                    @(posedge i_clk);
                    i_in_valid <= 1'b0;
                    while (pending_reports.size() != 0) @(posedge i_clk);
                end
                send_request(random_request());
            end
        end

        @(posedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        stim_done = 1;

        $display("tb: %0d requests over 7 register settings, %0d port reports checked",
                 n_reqs, n_reports);
        $display("tb: covered all commands, resets, pulse ends, slews, input and output stalls");
        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire

[trigger_cv_command_dispatcher.f]
+incdir+hw/rtl
hw/rtl/tcvd_pkg.sv
hw/rtl/tcvd_ctrl.sv
hw/rtl/tcvd_datapath.sv
hw/rtl/trigger_cv_command_dispatcher.sv
hw/rtl/tcvd_checker.sv
test/tb.sv
